// ----- rtl/spq_pkg.sv -----
// Shared constants for the speech priority queue.
// No dependencies.
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int TAG_WIDTH_DEF   = 16;
  localparam int NUM_CLS         = 5;

  localparam logic [2:0] CLS_INTERRUPT = 3'd0;
  localparam logic [2:0] CLS_CRITICAL  = 3'd1;
  localparam logic [2:0] CLS_DIALOGUE  = 3'd2;
  localparam logic [2:0] CLS_UI        = 3'd3;
  localparam logic [2:0] CLS_AMBIENT   = 3'd4;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

endpackage

// ----- rtl/spq_in_if.sv -----
// Command channel of the speech priority queue.
// Depends on spq_pkg for the default tag width.
interface spq_in_if #(
  parameter int TagWidth = spq_pkg::TAG_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [2:0]          priority_req;
  logic [TagWidth-1:0] message_tag;
  logic                text_is_empty;

  modport source (output valid, kind, priority_req, message_tag, text_is_empty,
                  input ready);
  modport sink   (input valid, kind, priority_req, message_tag, text_is_empty,
                  output ready);
endinterface

// ----- rtl/spq_out_if.sv -----
// Result channel of the speech priority queue.
// Depends on spq_pkg for the default tag width.
interface spq_out_if #(
  parameter int TagWidth = spq_pkg::TAG_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic                pop_valid;
  logic [2:0]          out_priority;
  logic [TagWidth-1:0] out_tag;
  logic                push_stored;
  logic                wake;
  logic                cancel_wanted;
  logic                queue_empty;
  logic [5:0]          pending_count;

  modport source (output valid, pop_valid, out_priority, out_tag, push_stored, wake,
                  cancel_wanted, queue_empty, pending_count, input ready);
  modport sink   (input valid, pop_valid, out_priority, out_tag, push_stored, wake,
                  cancel_wanted, queue_empty, pending_count, output ready);
endinterface

// ----- rtl/speech_priority_queue.sv -----
// Speech priority queue top level: per-class ring buffers in one tag memory.
// Depends on spq_pkg, spq_in_if and spq_out_if.
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid / ready | kind, priority_req, message_tag, text_is_empty
//  out_o   | out | valid / ready | pop_valid .. pending_count
//
// Each item passes through accept (memory read of the head to pop) and then
// execute (pointer update and memory write); the registered memory read sets this.
// An item waits in execute while the previous result has not been taken.
// Reset empties all classes and lowers the cancel flag; the memory is not cleared.
module speech_priority_queue #(
  parameter int QueueDepth = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int TagWidth   = spq_pkg::TAG_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int NC   = spq_pkg::NUM_CLS;
  localparam int PW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW   = $clog2(QueueDepth + 1);
  localparam int TW   = CW + 3;
  localparam int AW   = PW + 3;
  localparam int MEMD = NC << PW;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q;
  logic [CW-1:0] cnt_q  [NC];
  logic [CW-1:0] cnt_d  [NC];
  logic [PW-1:0] head_q [NC];
  logic [PW-1:0] head_d [NC];
  logic cancel_q, cancel_d;

  logic [1:0]          kind_q;
  logic [2:0]          cls_q;
  logic [TagWidth-1:0] tag_q;
  logic                empty_txt_q;
  logic [2:0]          pop_cls_q;

  logic [TagWidth-1:0] mem_q [MEMD];
  logic [TagWidth-1:0] rdata_q;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [2:0]          pop_cls;

  logic out_valid_q;
  logic out_free;
  logic accept;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free  = !out_valid_q || out_o.ready;

  // Head class for a pop: most urgent non-empty class.
  always_comb begin
    pop_cls = 3'(NC - 1);
    for (int i = NC - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) pop_cls = 3'(i);
    end
  end

  // Execute step.
  logic          r_pop_valid, r_stored, r_wake, r_cancel;
  logic [2:0]    r_pri;
  logic [TW-1:0] tot1, tot_new;
  logic          full;
  logic          vfound;
  logic [2:0]    victim;
  logic [PW+1:0] wsum;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      cnt_d[i]  = cnt_q[i];
      head_d[i] = head_q[i];
    end
    cancel_d    = cancel_q;
    we          = 1'b0;
    waddr       = '0;
    r_pop_valid = 1'b0;
    r_pri       = '0;
    r_stored    = 1'b0;
    r_wake      = 1'b0;
    r_cancel    = 1'b0;
    tot1        = '0;
    full        = 1'b0;
    vfound      = 1'b0;
    victim      = '0;
    wsum        = '0;
    if (state_q == S_EXEC && out_free) begin
      unique case (kind_q)
        spq_pkg::KIND_PUSH: begin
          if (!empty_txt_q && cls_q <= spq_pkg::CLS_AMBIENT) begin
            tot1 = '0;
            for (int i = 0; i < NC; i++) tot1 = tot1 + TW'(cnt_q[i]);
            if (cls_q == spq_pkg::CLS_AMBIENT && tot1 != '0) begin
              // drop
            end else begin
              if (cls_q == spq_pkg::CLS_INTERRUPT) begin
                for (int i = 0; i < NC; i++) cnt_d[i] = '0;
                cancel_d = 1'b1;
              end else if (cls_q == spq_pkg::CLS_CRITICAL) begin
                cnt_d[spq_pkg::CLS_UI]      = '0;
                cnt_d[spq_pkg::CLS_AMBIENT] = '0;
                cancel_d = 1'b1;
              end else if (cls_q == spq_pkg::CLS_UI) begin
                cnt_d[spq_pkg::CLS_UI] = '0;
              end
              tot1 = '0;
              for (int i = 0; i < NC; i++) tot1 = tot1 + TW'(cnt_d[i]);
              full = (tot1 >= TW'(QueueDepth));
              priority if (cnt_d[spq_pkg::CLS_AMBIENT] != '0) begin
                vfound = 1'b1; victim = spq_pkg::CLS_AMBIENT;
              end else if (cnt_d[spq_pkg::CLS_UI] != '0) begin
                vfound = 1'b1; victim = spq_pkg::CLS_UI;
              end else if (cnt_d[spq_pkg::CLS_CRITICAL] != '0) begin
                vfound = 1'b1; victim = spq_pkg::CLS_CRITICAL;
              end else if (cnt_d[spq_pkg::CLS_INTERRUPT] != '0) begin
                vfound = 1'b1; victim = spq_pkg::CLS_INTERRUPT;
              end else begin
                vfound = 1'b0;
              end
              if (!full || vfound) begin
                if (full) begin
                  // evict oldest of the least urgent class other than dialogue
                  cnt_d[victim]  = cnt_d[victim] - 1'b1;
                  head_d[victim] = ptr_inc(head_q[victim]);
                end
                wsum = (PW+2)'(head_d[cls_q]) + (PW+2)'(cnt_d[cls_q]);
                if (wsum >= (PW+2)'(QueueDepth)) wsum = wsum - (PW+2)'(QueueDepth);
                we           = 1'b1;
                waddr        = {cls_q, wsum[PW-1:0]};
                cnt_d[cls_q] = cnt_d[cls_q] + 1'b1;
                r_stored     = 1'b1;
                r_wake       = 1'b1;
              end
            end
          end
        end
        spq_pkg::KIND_POP: begin
          if (cnt_q[pop_cls_q] != '0) begin
            r_pop_valid       = 1'b1;
            r_pri             = pop_cls_q;
            cnt_d[pop_cls_q]  = cnt_q[pop_cls_q] - 1'b1;
            head_d[pop_cls_q] = ptr_inc(head_q[pop_cls_q]);
          end
        end
        spq_pkg::KIND_CLEAR: begin
          for (int i = 0; i < NC; i++) cnt_d[i] = '0;
          cancel_d = 1'b1;
          r_wake   = 1'b1;
        end
        spq_pkg::KIND_CANCEL: begin
          r_cancel = cancel_q;
          cancel_d = 1'b0;
        end
        default: ;
      endcase
    end
    tot_new = '0;
    for (int i = 0; i < NC; i++) tot_new = tot_new + TW'(cnt_d[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cancel_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
      end
    end else begin
      if (out_o.ready) out_valid_q <= 1'b0;
      if (accept) begin
        state_q <= S_EXEC;
      end else if (state_q == S_EXEC && out_free) begin
        state_q     <= S_IDLE;
        out_valid_q <= 1'b1;
        cancel_q    <= cancel_d;
        for (int i = 0; i < NC; i++) begin
          cnt_q[i]  <= cnt_d[i];
          head_q[i] <= head_d[i];
        end
      end
    end
  end

  // Item and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= in_i.kind;
      cls_q       <= in_i.priority_req;
      tag_q       <= in_i.message_tag;
      empty_txt_q <= in_i.text_is_empty;
      pop_cls_q   <= pop_cls;
    end
    if (state_q == S_EXEC && out_free) begin
      out_o.pop_valid     <= r_pop_valid;
      out_o.out_priority  <= r_pri;
      out_o.out_tag       <= r_pop_valid ? rdata_q : '0;
      out_o.push_stored   <= r_stored;
      out_o.wake          <= r_wake;
      out_o.cancel_wanted <= r_cancel;
      out_o.queue_empty   <= (tot_new == '0);
      out_o.pending_count <= 6'(tot_new);
    end
  end

  // Tag memory
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= tag_q;
    if (accept) rdata_q <= mem_q[{pop_cls, head_q[pop_cls]}];
  end

  assign out_o.valid = out_valid_q;

`ifndef SYNTHESIS
  logic [TW-1:0] tot_q;
  always_comb begin
    tot_q = '0;
    for (int i = 0; i < NC; i++) tot_q = tot_q + TW'(cnt_q[i]);
  end

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q <= TW'(QueueDepth))
    else $error("queue holds more entries than its depth");

  // a push other than an interrupt never removes a dialogue entry; an interrupt push empties every class
  a_dialogue_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_free && kind_q == spq_pkg::KIND_PUSH &&
     cls_q != spq_pkg::CLS_INTERRUPT)
      |=> cnt_q[spq_pkg::CLS_DIALOGUE] >= $past(cnt_q[spq_pkg::CLS_DIALOGUE]))
    else $error("push removed a dialogue entry");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.pop_valid && out_o.push_stored))
    else $error("result reports both pop and push");
`endif

endmodule

// ----- dv/tb_speech_priority_queue.sv -----
// Testbench for speech_priority_queue: random and directed commands checked
// against an in-bench model of the class-ordered queue.
// Depends on spq_pkg, spq_in_if, spq_out_if and the RTL top level.
`timescale 1ns / 100ps

module tb_speech_priority_queue;

  localparam int Depth    = spq_pkg::QUEUE_DEPTH_DEF;
  localparam int TagW     = spq_pkg::TAG_WIDTH_DEF;
  localparam int NumItems = 1750;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic [1:0]      kind;
    logic [2:0]      prio;
    logic [TagW-1:0] tag;
    logic            no_text;
  } cmd_t;

  typedef struct packed {
    logic            pop_valid;
    logic [2:0]      prio;
    logic [TagW-1:0] tag;
    logic            stored;
    logic            wake;
    logic            cancel;
    logic            empty;
    logic [5:0]      count;
  } resp_t;

  typedef struct packed {
    logic [2:0]      cls;
    logic [TagW-1:0] tag;
  } entry_t;

  logic clk_i;
  logic rst_ni;

  spq_in_if  #(.TagWidth(TagW)) cmd_ch ();
  spq_out_if #(.TagWidth(TagW)) resp_ch ();

  speech_priority_queue #(.QueueDepth(Depth), .TagWidth(TagW)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch.sink),
    .out_o (resp_ch.source)
  );

  cmd_t   pending_cmds[$];
  resp_t  expected_resps[$];
  entry_t model_q[$];
  logic   model_cancel;

  int  errors;
  int  accepted;
  int  checked;
  int  pops_seen;
  int  full_hits;
  int  idle_cycles;
  int  send_gap;
  int  stall_gap;
  bit  calm;
  bit  stim_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the model queue and return the response it gives.
  function automatic resp_t apply_cmd(cmd_t c);
    resp_t  r;
    entry_t e;
    entry_t kept[$];
    int     victim;
    int     pos;
    bit     ok;
    r = '0;
    case (c.kind)
      spq_pkg::KIND_PUSH: begin
        if (!c.no_text && c.prio <= spq_pkg::CLS_AMBIENT) begin
          ok = 1'b1;
          if (c.prio == spq_pkg::CLS_INTERRUPT) begin
            model_q.delete();
            model_cancel = 1'b1;
          end else if (c.prio == spq_pkg::CLS_CRITICAL || c.prio == spq_pkg::CLS_UI) begin
            kept = {};
            foreach (model_q[i])
              if (!(model_q[i].cls == spq_pkg::CLS_UI ||
                    (c.prio == spq_pkg::CLS_CRITICAL &&
                     model_q[i].cls == spq_pkg::CLS_AMBIENT)))
                kept.insert(kept.size(), model_q[i]);
            model_q = kept;
            if (c.prio == spq_pkg::CLS_CRITICAL) model_cancel = 1'b1;
          end else if (c.prio == spq_pkg::CLS_AMBIENT && model_q.size() != 0) begin
            ok = 1'b0;
          end
          if (ok && model_q.size() >= Depth) begin
            full_hits++;
            victim = -1;
            foreach (model_q[i])
              if (model_q[i].cls != spq_pkg::CLS_DIALOGUE &&
                  (victim < 0 || model_q[i].cls > model_q[victim].cls))
                victim = i;
            if (victim < 0) ok = 1'b0;
            else model_q.delete(victim);
          end
          if (ok) begin
            pos = model_q.size();
            foreach (model_q[i])
              if (model_q[i].cls > c.prio && pos == model_q.size()) pos = i;
            e.cls = c.prio;
            e.tag = c.tag;
            model_q.insert(pos, e);
            r.stored = 1'b1;
            r.wake   = 1'b1;
          end
        end
      end
      spq_pkg::KIND_POP: begin
        if (model_q.size() != 0) begin
          e = model_q.pop_front();
          r.pop_valid = 1'b1;
          r.prio      = e.cls;
          r.tag       = e.tag;
        end
      end
      spq_pkg::KIND_CLEAR: begin
        model_q.delete();
        model_cancel = 1'b1;
        r.wake = 1'b1;
      end
      default: begin
        r.cancel = model_cancel;
        model_cancel = 1'b0;
      end
    endcase
    r.empty = (model_q.size() == 0);
    r.count = 6'(model_q.size());
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] k, logic [2:0] p, logic [TagW-1:0] t,
                                    logic nt);
    cmd_t c;
    c.kind = k; c.prio = p; c.tag = t; c.no_text = nt;
    return c;
  endfunction

  // Append one command to the stimulus queue.
  function automatic void add_cmd(cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Mostly dialogue and UI pushes so the queue fills and evicts; mode 1 favours pops.
  function automatic cmd_t rand_cmd(int mode);
    cmd_t c;
    int   roll;
    c.tag     = TagW'($urandom);
    c.no_text = ($urandom_range(0, 19) == 0);
    roll = $urandom_range(0, 99);
    if (mode == 0) begin
      c.kind = (roll < 80) ? spq_pkg::KIND_PUSH : (roll < 92) ? spq_pkg::KIND_POP :
               (roll < 95) ? spq_pkg::KIND_CLEAR : spq_pkg::KIND_CANCEL;
    end else begin
      c.kind = (roll < 40) ? spq_pkg::KIND_PUSH : (roll < 85) ? spq_pkg::KIND_POP :
               (roll < 92) ? spq_pkg::KIND_CLEAR : spq_pkg::KIND_CANCEL;
    end
    roll = $urandom_range(0, 99);
    c.prio = (roll < 2)  ? spq_pkg::CLS_INTERRUPT :
             (roll < 12) ? spq_pkg::CLS_CRITICAL :
             (roll < 60) ? spq_pkg::CLS_DIALOGUE :
             (roll < 80) ? spq_pkg::CLS_UI :
             (roll < 95) ? spq_pkg::CLS_AMBIENT : 3'($urandom_range(5, 7));
    if (c.kind != spq_pkg::KIND_PUSH && $urandom_range(0, 3) != 0) begin
      c.prio = '0; c.tag = '0; c.no_text = 1'b0;
    end
    return c;
  endfunction

  initial begin
    int mode;
    errors = 0; accepted = 0; checked = 0; pops_seen = 0; full_hits = 0;
    model_cancel = 1'b0;
    calm = 1'b0;
    stim_done = 1'b0;
    // directed: every class, extremes of the tag, empty text, bad class,
    // pop on empty, clear and cancel reads
    add_cmd(make_cmd(spq_pkg::KIND_POP, '0, '0, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_CANCEL, '0, '0, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_AMBIENT, '1, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_AMBIENT, 16'h1234, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_DIALOGUE, '0, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_UI, 16'h00a5, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_UI, 16'h5a00, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_DIALOGUE, 16'hffff, 1'b1));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, 3'd7, 16'h7777, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, 3'd5, 16'h5555, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_CRITICAL, 16'h8001, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_CANCEL, 3'd7, '1, 1'b1));
    add_cmd(make_cmd(spq_pkg::KIND_CANCEL, '0, '0, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_INTERRUPT, 16'h4321, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_POP, 3'd7, '1, 1'b1));
    add_cmd(make_cmd(spq_pkg::KIND_POP, '0, '0, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_DIALOGUE, 16'h0101, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_CLEAR, 3'd7, '1, 1'b1));
    add_cmd(make_cmd(spq_pkg::KIND_CANCEL, '0, '0, 1'b0));
    // fill with dialogue beyond the depth so the newcomer is dropped
    for (int i = 0; i < Depth + 2; i++)
      add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_DIALOGUE, TagW'(i), 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_CRITICAL, 16'hc0de, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_PUSH, spq_pkg::CLS_UI, 16'hbeef, 1'b0));
    add_cmd(make_cmd(spq_pkg::KIND_CLEAR, '0, '0, 1'b0));
    for (int i = 0; i < NumItems; i++) begin
      // alternate filling and draining phases
      mode = ((i / 150) % 2);
      add_cmd(rand_cmd(mode));
    end
    stim_done = 1'b1;
  end

  // driver: inputs change on the falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid         <= 1'b0;
      cmd_ch.kind          <= '0;
      cmd_ch.priority_req  <= '0;
      cmd_ch.message_tag   <= '0;
      cmd_ch.text_is_empty <= 1'b0;
      resp_ch.ready        <= 1'b0;
      send_gap  <= 0;
      stall_gap <= 0;
    end else begin
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          cmd_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 14) - 1;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          cmd_ch.valid         <= 1'b1;
          cmd_ch.kind          <= c.kind;
          cmd_ch.priority_req  <= c.prio;
          cmd_ch.message_tag   <= c.tag;
          cmd_ch.text_is_empty <= c.no_text;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
      if (stall_gap > 0) begin
        stall_gap <= stall_gap - 1;
        resp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_gap <= $urandom_range(1, 14) - 1;
        resp_ch.ready <= 1'b0;
      end else begin
        resp_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: sample on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (resp_ch.valid && resp_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_resps.insert(expected_resps.size(),
                              apply_cmd(make_cmd(cmd_ch.kind, cmd_ch.priority_req,
                                                 cmd_ch.message_tag,
                                                 cmd_ch.text_is_empty)));
        accepted <= accepted + 1;
      end
      if (resp_ch.valid && resp_ch.ready) begin
        resp_t got;
        resp_t want;
        got.pop_valid = resp_ch.pop_valid;
        got.prio      = resp_ch.out_priority;
        got.tag       = resp_ch.out_tag;
        got.stored    = resp_ch.push_stored;
        got.wake      = resp_ch.wake;
        got.cancel    = resp_ch.cancel_wanted;
        got.empty     = resp_ch.queue_empty;
        got.count     = resp_ch.pending_count;
        if (expected_resps.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, got);
          errors++;
        end else begin
          want = expected_resps.pop_front();
          checked++;
          if (want.pop_valid) pops_seen++;
          if (got.pop_valid !== want.pop_valid)
            $display("%0t: pop_valid exp %0b got %0b", $time, want.pop_valid, got.pop_valid);
          if (got.prio !== want.prio)
            $display("%0t: out_priority exp %0d got %0d", $time, want.prio, got.prio);
          if (got.tag !== want.tag)
            $display("%0t: out_tag exp %h got %h", $time, want.tag, got.tag);
          if (got.stored !== want.stored)
            $display("%0t: push_stored exp %0b got %0b", $time, want.stored, got.stored);
          if (got.wake !== want.wake)
            $display("%0t: wake exp %0b got %0b", $time, want.wake, got.wake);
          if (got.cancel !== want.cancel)
            $display("%0t: cancel_wanted exp %0b got %0b", $time, want.cancel, got.cancel);
          if (got.empty !== want.empty)
            $display("%0t: queue_empty exp %0b got %0b", $time, want.empty, got.empty);
          if (got.count !== want.count)
            $display("%0t: pending_count exp %0d got %0d", $time, want.count, got.count);
          if (got !== want) errors++;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    fork
      begin
        wait (stim_done);
        while (pending_cmds.size() >= 200) @(posedge clk_i);
        calm = 1'b1;
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_resps.size() != 0)
          @(posedge clk_i);
        repeat (10) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= WatchdogLimit);
        $display("watchdog: nothing accepted for %0d cycles", WatchdogLimit);
        errors++;
      end
    join_any
    $display("%0d commands sent, %0d results checked, %0d pops returned an entry,",
             accepted, checked, pops_seen);
    $display("full-queue pushes seen %0d, leftover expectations %0d",
             full_hits, expected_resps.size());
    errors += expected_resps.size();
    if (errors == 0)
      $display("tb_speech_priority_queue passed");
    else
      $display("tb_speech_priority_queue failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/speech_priority_queue.sv
dv/tb_speech_priority_queue.sv
